// File: rtl/lslf_pkg.sv
// Shared types and constants for the least-squares line fit block.
`default_nettype none

package lslf_pkg;

    // Parameter defaults
    localparam int DEF_MAX_PAIRS   = 256;
    localparam int DEF_SAMPLE_BITS = 12;

    // Result format: signed Q16.16, quotient taken one extra bit for rounding
    localparam int RES_W       = 32;
    localparam int Q_FRAC_BITS = 16;
    localparam int ROUND_SHIFT = Q_FRAC_BITS + 1;
    localparam int QUOT_BITS   = 2 * ROUND_SHIFT;

    // Magnitude limits of the rounded quotient, positive and negative side
    localparam logic [QUOT_BITS-1:0] POS_LIMIT =
        {{(QUOT_BITS-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
    localparam logic [QUOT_BITS-1:0] NEG_LIMIT =
        {{(QUOT_BITS-RES_W){1'b0}}, 1'b1, {(RES_W-1){1'b0}}};

    // Fit sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LOAD,
        S_MUL_STEP,
        S_DEN_CHECK,
        S_ABS,
        S_DIV_INIT,
        S_DIV_OVF,
        S_DIV_STEP,
        S_ROUND,
        S_FINISH,
        S_DONE
    } t_fit_state;

    // Product terms, in evaluation order; odd ones are subtracted
    typedef enum logic [2:0] {
        T_N_SXX,
        T_SX_SX,
        T_N_SXY,
        T_SX_SY,
        T_SXX_SY,
        T_SX_SXY
    } t_term;

    // Status handed from the fit engine to the top level
    typedef struct packed {
        logic done;
        logic singular;
        logic saturated;
    } t_fit_status;

endpackage

`default_nettype wire

// File: rtl/least_squares_line_fit_top.sv
// Top level of the least-squares line fit: sample accumulation and result port.
//
//  Channel   Direction  Handshake             Payload
//  -------   ---------  --------------------  ------------------------------------------
//  sample    in         start & !busy         i_x_value, i_y_value, i_last_sample
//  result    out        o_result_valid strobe o_slope, o_intercept, o_singular, o_saturated
//
//  A sample without the last mark is accepted; busy stays low and the next
//  sample may follow in the next cycle.
//  A marked sample raises busy while the shared add/subtract unit works through six
//  shift-add products and two 34-step restoring divisions; a singular run ends after
//  the denominator, which is the first two products.
//  The result strobe lasts one cycle and the receiver cannot stall it; busy drops in
//  the cycle after the strobe. Reset is synchronous and clears all sums.
`default_nettype none

module least_squares_line_fit_top #(
    parameter int MAX_PAIRS   = lslf_pkg::DEF_MAX_PAIRS,
    parameter int SAMPLE_BITS = lslf_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [SAMPLE_BITS-1:0] i_x_value,
    input  wire logic signed [SAMPLE_BITS-1:0] i_y_value,
    input  wire logic                          i_last_sample,
    output logic                               o_result_valid,
    output logic signed [lslf_pkg::RES_W-1:0]  o_slope,
    output logic signed [lslf_pkg::RES_W-1:0]  o_intercept,
    output logic                               o_singular,
    output logic                               o_saturated
);

    import lslf_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;

    logic [CNT_W-1:0]   r_count,  n_count;
    logic [SUM_W-1:0]   r_sum_x,  n_sum_x;
    logic [SUM_W-1:0]   r_sum_y,  n_sum_y;
    logic [SQ_W-1:0]    r_sum_xx, n_sum_xx;
    logic [SQ_W-1:0]    r_sum_xy, n_sum_xy;
    logic               r_busy,   n_busy;
    logic               r_go,     n_go;

    logic                          accept;
    logic signed [2*SAMPLE_BITS-1:0] w_xx;
    logic signed [2*SAMPLE_BITS-1:0] w_xy;
    t_fit_status                   w_status;
    logic [RES_W-1:0]              w_slope;
    logic [RES_W-1:0]              w_icpt;

    assign accept = start && !busy;
    assign w_xx   = (2*SAMPLE_BITS)'(i_x_value) * (2*SAMPLE_BITS)'(i_x_value);
    assign w_xy   = (2*SAMPLE_BITS)'(i_x_value) * (2*SAMPLE_BITS)'(i_y_value);

    // Accumulate one transaction, drop pairs past the run limit, clear after a result
    always_comb begin
        n_count  = r_count;
        n_sum_x  = r_sum_x;
        n_sum_y  = r_sum_y;
        n_sum_xx = r_sum_xx;
        n_sum_xy = r_sum_xy;
        n_busy   = r_busy;
        n_go     = accept && i_last_sample;
        if (accept && (r_count < CNT_W'(MAX_PAIRS))) begin
            n_count  = r_count + 1'b1;
            n_sum_x  = r_sum_x + {{(SUM_W-SAMPLE_BITS){i_x_value[SAMPLE_BITS-1]}}, i_x_value};
            n_sum_y  = r_sum_y + {{(SUM_W-SAMPLE_BITS){i_y_value[SAMPLE_BITS-1]}}, i_y_value};
            n_sum_xx = r_sum_xx + {{(SQ_W-2*SAMPLE_BITS){w_xx[2*SAMPLE_BITS-1]}}, w_xx};
            n_sum_xy = r_sum_xy + {{(SQ_W-2*SAMPLE_BITS){w_xy[2*SAMPLE_BITS-1]}}, w_xy};
        end
        if (accept && i_last_sample) begin
            n_busy = 1'b1;
        end else if (w_status.done) begin
            n_busy   = 1'b0;
            n_count  = '0;
            n_sum_x  = '0;
            n_sum_y  = '0;
            n_sum_xx = '0;
            n_sum_xy = '0;
        end
    end

    // Sums and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_xx <= '0;
            r_sum_xy <= '0;
            r_busy   <= 1'b0;
            r_go     <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_sum_x  <= n_sum_x;
            r_sum_y  <= n_sum_y;
            r_sum_xx <= n_sum_xx;
            r_sum_xy <= n_sum_xy;
            r_busy   <= n_busy;
            r_go     <= n_go;
        end
    end

    // Fit engine
    lslf_fit_engine #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_PAIRS   (MAX_PAIRS),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .SQ_W        (SQ_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (r_go),
        .i_count     (r_count),
        .i_sum_x     (r_sum_x),
        .i_sum_y     (r_sum_y),
        .i_sum_xx    (r_sum_xx),
        .i_sum_xy    (r_sum_xy),
        .o_status    (w_status),
        .o_slope     (w_slope),
        .o_intercept (w_icpt)
    );

    // Result port
    assign busy           = r_busy;
    assign o_result_valid = w_status.done;
    assign o_slope        = w_slope;
    assign o_intercept    = w_icpt;
    assign o_singular     = w_status.singular;
    assign o_saturated    = w_status.saturated;

`ifndef ASSERT_OFF
    // A marked transaction always holds the block busy in the next cycle
    a_busy_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_sample) |=> busy)
        else $error("marked sample did not start a fit");

    // Results appear only while a fit is in progress
    a_result_in_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe outside a fit");

    // Sums are cleared once a result has gone out
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> (r_count == '0 && r_sum_x == '0 && r_sum_xx == '0))
        else $error("sums not cleared after a result");

    // The pair count never passes the run limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_count <= CNT_W'(MAX_PAIRS)))
        else $error("pair count beyond run limit");
`endif

endmodule

`default_nettype wire

// File: rtl/lslf_fit_engine.sv
// Fit engine: shared shift-add multiplier and restoring divider under a sequencer.
`default_nettype none

module lslf_fit_engine #(
    parameter int SAMPLE_BITS = lslf_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_PAIRS   = lslf_pkg::DEF_MAX_PAIRS,
    parameter int CNT_W       = $clog2(MAX_PAIRS + 1),
    parameter int SUM_W       = SAMPLE_BITS + CNT_W,
    parameter int SQ_W        = 2 * SAMPLE_BITS + CNT_W
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_go,
    input  wire logic [CNT_W-1:0]            i_count,
    input  wire logic [SUM_W-1:0]            i_sum_x,
    input  wire logic [SUM_W-1:0]            i_sum_y,
    input  wire logic [SQ_W-1:0]             i_sum_xx,
    input  wire logic [SQ_W-1:0]             i_sum_xy,
    output lslf_pkg::t_fit_status            o_status,
    output logic [lslf_pkg::RES_W-1:0]       o_slope,
    output logic [lslf_pkg::RES_W-1:0]       o_intercept
);

    import lslf_pkg::*;

    // Products and their differences fit W bits; the adder has headroom for both uses
    localparam int W      = SQ_W + SUM_W + 1;
    localparam int AW     = ((W > QUOT_BITS) ? W : QUOT_BITS) + 2;
    localparam int STEPS  = (SUM_W > QUOT_BITS) ? SUM_W : QUOT_BITS;
    localparam int CTR_W  = $clog2(STEPS);

    t_fit_state             r_state,  n_state;
    t_term                  r_term,   n_term;
    logic [CTR_W-1:0]       r_cnt,    n_cnt;
    logic [W-1:0]           r_acc,    n_acc;
    logic [W-1:0]           r_mcand,  n_mcand;
    logic [SUM_W-1:0]       r_mplier, n_mplier;
    logic [W-1:0]           r_den,    n_den;
    logic [W-1:0]           r_rem,    n_rem;
    logic [QUOT_BITS-1:0]   r_dq,     n_dq;
    logic                   r_neg,    n_neg;
    logic                   r_ovf,    n_ovf;
    logic [RES_W-1:0]       r_slope,  n_slope;
    logic [RES_W-1:0]       r_icpt,   n_icpt;
    logic                   r_sing,   n_sing;
    logic                   r_sat,    n_sat;

    // Shared adder/subtractor
    logic [AW-1:0]          add_a;
    logic [AW-1:0]          add_b;
    logic                   add_sub;
    logic [AW-1:0]          add_sum;

    // Operand selection for the current product term
    logic [W-1:0]           op_a;
    logic [SUM_W-1:0]       op_b;
    logic                   term_sub;

    logic                   last_bit;
    logic                   fits;
    logic                   clip;
    logic [QUOT_BITS-1:0]   limit;
    logic [QUOT_BITS-1:0]   m_sel;

    assign add_sum = add_a + (add_b ^ {AW{add_sub}}) + AW'(add_sub);

    // Term operands: multiplicand sign-extended to W, multiplier kept two's complement
    always_comb begin
        op_a     = {{(W-SQ_W){i_sum_xx[SQ_W-1]}}, i_sum_xx};
        op_b     = {{(SUM_W-CNT_W){1'b0}}, i_count};
        term_sub = 1'b0;
        case (r_term)
            T_N_SXX: begin
                op_a = {{(W-SQ_W){i_sum_xx[SQ_W-1]}}, i_sum_xx};
                op_b = {{(SUM_W-CNT_W){1'b0}}, i_count};
            end
            T_SX_SX: begin
                op_a     = {{(W-SUM_W){i_sum_x[SUM_W-1]}}, i_sum_x};
                op_b     = i_sum_x;
                term_sub = 1'b1;
            end
            T_N_SXY: begin
                op_a = {{(W-SQ_W){i_sum_xy[SQ_W-1]}}, i_sum_xy};
                op_b = {{(SUM_W-CNT_W){1'b0}}, i_count};
            end
            T_SX_SY: begin
                op_a     = {{(W-SUM_W){i_sum_x[SUM_W-1]}}, i_sum_x};
                op_b     = i_sum_y;
                term_sub = 1'b1;
            end
            T_SXX_SY: begin
                op_a = {{(W-SQ_W){i_sum_xx[SQ_W-1]}}, i_sum_xx};
                op_b = i_sum_y;
            end
            T_SX_SXY: begin
                op_a     = {{(W-SQ_W){i_sum_xy[SQ_W-1]}}, i_sum_xy};
                op_b     = i_sum_x;
                term_sub = 1'b1;
            end
            default: begin
                op_a     = '0;
                op_b     = '0;
                term_sub = 1'b0;
            end
        endcase
    end

    // State register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= T_N_SXX;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_cnt   <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_dq     <= n_dq;
        r_neg    <= n_neg;
        r_ovf    <= n_ovf;
        r_slope  <= n_slope;
        r_icpt   <= n_icpt;
        r_sing   <= n_sing;
        r_sat    <= n_sat;
    end

    // Sequencer: next state and the shared unit's operation
    always_comb begin
        n_state  = r_state;
        n_term   = r_term;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_den    = r_den;
        n_rem    = r_rem;
        n_dq     = r_dq;
        n_neg    = r_neg;
        n_ovf    = r_ovf;
        n_slope  = r_slope;
        n_icpt   = r_icpt;
        n_sing   = r_sing;
        n_sat    = r_sat;
        add_a    = '0;
        add_b    = '0;
        add_sub  = 1'b0;
        last_bit = (r_cnt == CTR_W'(SUM_W - 1));
        fits     = 1'b0;
        limit    = r_neg ? NEG_LIMIT : POS_LIMIT;
        clip     = r_ovf || (r_dq > limit);
        m_sel    = clip ? limit : r_dq;

        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_acc   = '0;
                    n_term  = T_N_SXX;
                    n_sing  = 1'b0;
                    n_sat   = 1'b0;
                    n_state = S_MUL_LOAD;
                end
            end

            S_MUL_LOAD: begin
                n_mcand  = op_a;
                n_mplier = op_b;
                n_cnt    = '0;
                n_state  = S_MUL_STEP;
            end

            // One multiplier bit a cycle; the sign bit carries negative weight
            S_MUL_STEP: begin
                add_a   = {{(AW-W){r_acc[W-1]}}, r_acc};
                add_b   = {{(AW-W){r_mcand[W-1]}}, r_mcand};
                add_sub = last_bit ^ term_sub;
                if (r_mplier[0]) begin
                    n_acc = add_sum[W-1:0];
                end
                n_mcand  = {r_mcand[W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[SUM_W-1:1]};
                n_cnt    = r_cnt + 1'b1;
                if (last_bit) begin
                    case (r_term)
                        T_N_SXX: begin
                            n_term  = T_SX_SX;
                            n_state = S_MUL_LOAD;
                        end
                        T_SX_SX:  n_state = S_DEN_CHECK;
                        T_N_SXY: begin
                            n_term  = T_SX_SY;
                            n_state = S_MUL_LOAD;
                        end
                        T_SX_SY:  n_state = S_ABS;
                        T_SXX_SY: begin
                            n_term  = T_SX_SXY;
                            n_state = S_MUL_LOAD;
                        end
                        T_SX_SXY: n_state = S_ABS;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end

            // Denominator is never negative; zero means a singular run
            S_DEN_CHECK: begin
                n_den = r_acc;
                n_acc = '0;
                if (r_acc == '0) begin
                    n_sing  = 1'b1;
                    n_slope = '0;
                    n_icpt  = '0;
                    n_sat   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_term  = T_N_SXY;
                    n_state = S_MUL_LOAD;
                end
            end

            // Numerator magnitude and sign
            S_ABS: begin
                n_neg   = r_acc[W-1];
                add_b   = {{(AW-W){r_acc[W-1]}}, r_acc};
                add_sub = r_acc[W-1];
                n_acc   = add_sum[W-1:0];
                n_state = S_DIV_INIT;
            end

            // Dividend is |num| << 17: top part to the remainder, rest queued
            S_DIV_INIT: begin
                n_rem   = r_acc >> ROUND_SHIFT;
                n_dq    = {r_acc[ROUND_SHIFT-1:0], {ROUND_SHIFT{1'b0}}};
                n_ovf   = 1'b0;
                n_state = S_DIV_OVF;
            end

            // Quotient would not fit the quotient register: clip straight away
            S_DIV_OVF: begin
                add_a   = AW'(r_rem);
                add_b   = AW'(r_den);
                add_sub = 1'b1;
                n_cnt   = '0;
                if (!add_sum[AW-1]) begin
                    n_ovf   = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DIV_STEP;
                end
            end

            // Restoring division, one quotient bit a cycle
            S_DIV_STEP: begin
                add_a   = AW'({r_rem, r_dq[QUOT_BITS-1]});
                add_b   = AW'(r_den);
                add_sub = 1'b1;
                fits    = !add_sum[AW-1];
                n_rem   = fits ? add_sum[W-1:0] : {r_rem[W-2:0], r_dq[QUOT_BITS-1]};
                n_dq    = {r_dq[QUOT_BITS-2:0], fits};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CTR_W'(QUOT_BITS - 1)) begin
                    n_state = S_ROUND;
                end
            end

            // Round half away from zero on the magnitude
            S_ROUND: begin
                add_a   = AW'(r_dq);
                add_b   = AW'(1'b1);
                n_dq    = add_sum[QUOT_BITS:1];
                n_state = S_FINISH;
            end

            // Saturate, restore the sign and store
            S_FINISH: begin
                add_b   = AW'(m_sel);
                add_sub = r_neg;
                n_sat   = r_sat | clip;
                if (r_term == T_SX_SY) begin
                    n_slope = add_sum[RES_W-1:0];
                    n_acc   = '0;
                    n_term  = T_SXX_SY;
                    n_state = S_MUL_LOAD;
                end else begin
                    n_icpt  = add_sum[RES_W-1:0];
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    assign o_status.done      = (r_state == S_DONE);
    assign o_status.singular  = r_sing;
    assign o_status.saturated = r_sat;
    assign o_slope            = r_slope;
    assign o_intercept        = r_icpt;

`ifndef ASSERT_OFF
    // The result strobe lasts one cycle and the engine then goes idle
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("fit engine did not return to idle after a result");

    // A singular result carries zero slope and intercept and no clip
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.done && o_status.singular) |->
            (o_slope == '0 && o_intercept == '0 && !o_status.saturated))
        else $error("singular result with non-zero fields");

    // Division only ever starts with a positive denominator
    a_den_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_OVF) |-> (r_den != '0 && !r_den[W-1]))
        else $error("division started with a non-positive denominator");

    // Partial remainder stays below the denominator throughout the division
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_STEP) |-> (r_rem < r_den))
        else $error("partial remainder out of range");
`endif

endmodule

`default_nettype wire
